FILE: design/lbp_pkg.sv
// Shared types, constants and helpers of the lifetime-aware buffer packer.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

	localparam int MAX_BUFFERS_DEF = 32;
	localparam int ALIGN_W         = 5;
	localparam logic [ALIGN_W-1:0] ALIGN_RESET = 5'd8;
	localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 5'd16;
	localparam int SIZE_W  = 32;
	localparam int USE_W   = 16;
	localparam int OFF_W   = 40;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int SC_W    = 8;

	typedef struct packed {
		logic              have;
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  idx;
	} pick_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              load;
		logic [SIZE_W-1:0] ld_size;
		logic [USE_W-1:0]  ld_first;
		logic [USE_W-1:0]  ld_last;
		logic [CNT_W-1:0]  count;
		logic [IDX_W-1:0]  cur_idx;
		logic [USE_W-1:0]  cur_first;
		logic [USE_W-1:0]  cur_last;
		logic              tok_step;
		logic              tok_clr;
		logic              wr_cur;
		logic [OFF_W-1:0]  wr_off;
		logic [OFF_W:0]    wr_end;
		logic              clr_marks;
		logic [OFF_W-1:0]  probe_lo;
		logic [OFF_W:0]    probe_hi;
	} cell_ctrl_t;

	typedef struct packed {
		pick_t             pick;
		logic              tok;
		logic              cur;
		logic              cand_vld;
		logic [OFF_W-1:0]  off_sel;
		logic [OFF_W-1:0]  end_sel;
		logic [USE_W-1:0]  first_sel;
		logic [USE_W-1:0]  last_sel;
		logic              clash;
	} cell_stat_t;

	function automatic logic [OFF_W-1:0] round_up(input logic [OFF_W-1:0] v,
			input logic [ALIGN_W-1:0] lg);
		logic [OFF_W-1:0] mask;
		mask = (OFF_W'(1) << lg) - OFF_W'(1);
		return (v + mask) & ~mask;
	endfunction

endpackage
`default_nettype wire

FILE: design/lbp_if.sv
// Valid/ready channel interfaces for buffer descriptors and placement results.
`timescale 1ns / 1ps
`default_nettype none
interface lbp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] size_bytes;
	logic [15:0] first_use;
	logic [15:0] last_use;
	logic        final_buffer;
	modport source(output valid, output size_bytes, output first_use, output last_use,
		output final_buffer, input ready);
	modport sink(input valid, input size_bytes, input first_use, input last_use,
		input final_buffer, output ready);
endinterface

interface lbp_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  buffer_index;
	logic [39:0] slot_offset;
	logic [39:0] pool_bytes;
	logic        dropped_any;
	logic        last_result;
	modport source(output valid, output buffer_index, output slot_offset, output pool_bytes,
		output dropped_any, output last_result, input ready);
	modport sink(input valid, input buffer_index, input slot_offset, input pool_bytes,
		input dropped_any, input last_result, output ready);
endinterface
`default_nettype wire

FILE: design/lbp_cell.sv
// One buffer slot: descriptor, placement, pick-chain stage and token stage.
`timescale 1ns / 1ps
`default_nettype none
module lbp_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lbp_pkg::cell_ctrl_t ctrl,
	input  lbp_pkg::pick_t      pick_in,
	input  wire                 tok_in,
	output lbp_pkg::cell_stat_t stat
);
	import lbp_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [USE_W-1:0]  first_q;
	logic [USE_W-1:0]  last_q;
	logic [OFF_W-1:0]  off_q;
	logic [OFF_W:0]    end_q;
	logic              placed_q;
	logic              tok_q;
	pick_t             pick_q;
	logic              active;
	logic              is_cur;
	logic              live_ovl;
	logic              range_ovl;

	assign active = CNT_W'(IDX) < ctrl.count;
	assign is_cur = active && (ctrl.cur_idx == IDX_W'(IDX));

	always_ff @(posedge clk) begin
		if (ctrl.load && ctrl.count == CNT_W'(IDX)) begin
			size_q  <= ctrl.ld_size;
			first_q <= ctrl.ld_first;
			last_q  <= ctrl.ld_last;
		end
		if (ctrl.wr_cur && is_cur) begin
			off_q <= ctrl.wr_off;
			end_q <= ctrl.wr_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= 1'b0;
			tok_q    <= 1'b0;
			pick_q   <= '0;
		end else begin
			if (ctrl.clr_marks)
				placed_q <= 1'b0;
			else if (ctrl.wr_cur && is_cur)
				placed_q <= 1'b1;
			if (ctrl.tok_clr)
				tok_q <= 1'b0;
			else if (ctrl.tok_step)
				tok_q <= tok_in;
			// running max: strict compare keeps the lower index on equal sizes
			if (active && !placed_q && (!pick_in.have || size_q > pick_in.size))
				pick_q <= '{have: 1'b1, size: size_q, idx: IDX_W'(IDX)};
			else
				pick_q <= pick_in;
		end
	end

	assign live_ovl  = !(last_q < ctrl.cur_first || ctrl.cur_last < first_q);
	assign range_ovl = !(ctrl.probe_hi <= {1'b0, off_q} || end_q <= {1'b0, ctrl.probe_lo});

	always_comb begin
		stat.pick      = pick_q;
		stat.tok       = tok_q;
		stat.cur       = is_cur;
		stat.cand_vld  = tok_q && active && placed_q;
		stat.off_sel   = tok_q ? off_q : '0;
		stat.end_sel   = tok_q ? end_q[OFF_W-1:0] : '0;
		stat.first_sel = is_cur ? first_q : '0;
		stat.last_sel  = is_cur ? last_q : '0;
		stat.clash     = active && placed_q && live_ovl && range_ovl;
	end

endmodule
`default_nettype wire

FILE: design/lifetime_aware_buffer_packer.sv
// Top level: load, largest-first placement sequencer over a chain of buffer cells, result output.
//
//  channel   dir  handshake      payload
//  items     in   valid/ready    size_bytes, first_use, last_use, final_buffer
//  results   out  valid/ready    buffer_index, slot_offset, pool_bytes, dropped_any, last_result
//  cfg       in   cfg_we         cfg_data = align_log2
//
// Loading accepts items back to back while in the load state. After the final item each
// buffer goes through the pick chain settling, one fetch of its lifetime, the scan in which
// the token walks the chain offering two candidates per cell plus zero and high-water,
// a three-stage align/clash pipeline and the commit and write steps.
// Results then leave at one per cycle; a stalled results sink holds the emit sequencer.
// Reset clears all control state; items are not taken until the whole set is delivered.
`timescale 1ns / 1ps
`default_nettype none
module lifetime_aware_buffer_packer #(
	parameter int MAX_BUFFERS = lbp_pkg::MAX_BUFFERS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [lbp_pkg::ALIGN_W-1:0]  cfg_data,
	lbp_in_if.sink                      items,
	lbp_out_if.source                   results
);
	import lbp_pkg::*;

	typedef enum logic [9:0] {
		S_LOAD   = 10'b0000000001,
		S_PICK   = 10'b0000000010,
		S_CUR    = 10'b0000000100,
		S_SCAN   = 10'b0000001000,
		S_DRAIN  = 10'b0000010000,
		S_COMMIT = 10'b0000100000,
		S_WRITE  = 10'b0001000000,
		S_POOL   = 10'b0010000000,
		S_EMIT   = 10'b0100000000,
		S_LAST   = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [ALIGN_W-1:0] align_q;
	logic [ALIGN_W-1:0] lg;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  placed_n_q;
	logic [CNT_W-1:0]  wait_q;
	logic [CNT_W-1:0]  oi_q;
	logic [SC_W-1:0]   sc_q;
	logic [1:0]        drain_q;
	logic              ovf_q;
	logic [OFF_W-1:0]  hw_q;
	logic [OFF_W-1:0]  pool_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic [SIZE_W-1:0] cur_size_q;
	logic [USE_W-1:0]  cur_first_q;
	logic [USE_W-1:0]  cur_last_q;
	logic              found_q;
	logic [OFF_W-1:0]  best_gap_q;
	logic [OFF_W-1:0]  best_cand_q;
	logic [OFF_W-1:0]  best_off_q;
	logic [OFF_W:0]    end_new_q;

	logic              vld_s1, vld_s2, vld_s3;
	logic [OFF_W-1:0]  cand_s1, cand_s2, cand_s3;
	logic [OFF_W-1:0]  al_s2, al_s3;
	logic [OFF_W-1:0]  gap_s3;
	logic [OFF_W:0]    hi_s3;

	logic              ov_q;
	logic [IDX_W-1:0]  r_idx_q;
	logic [OFF_W-1:0]  r_off_q;
	logic [OFF_W-1:0]  r_pool_q;
	logic              r_drop_q;
	logic              r_last_q;

	cell_ctrl_t        ctrl;
	cell_stat_t        stat [MAX_BUFFERS];
	logic              tok_inject;
	logic              any_cand, any_clash;
	logic [OFF_W-1:0]  bus_off, bus_end;
	logic [USE_W-1:0]  bus_first, bus_last;
	logic [MAX_BUFFERS-1:0] tok_vec, cur_vec;
	logic              in_xfer, out_free, last_sc, take;

	assign lg       = (align_q > ALIGN_MAX) ? ALIGN_MAX : align_q;
	assign in_xfer  = items.valid && items.ready;
	assign out_free = !ov_q || results.ready;
	assign last_sc  = sc_q == SC_W'(2 * MAX_BUFFERS + 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			align_q <= ALIGN_RESET;
		else if (cfg_we)
			align_q <= cfg_data;
	end

	// cell chain
	for (genvar i = 0; i < MAX_BUFFERS; i++) begin : g_cell
		pick_t pin;
		logic  tin;
		if (i == 0) begin : g_head
			assign pin = '0;
			assign tin = tok_inject;
		end else begin : g_link
			assign pin = stat[i-1].pick;
			assign tin = stat[i-1].tok;
		end
		lbp_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.pick_in(pin), .tok_in(tin), .stat(stat[i])
		);
	end

	always_comb begin
		any_cand  = 1'b0;
		any_clash = 1'b0;
		bus_off   = '0;
		bus_end   = '0;
		bus_first = '0;
		bus_last  = '0;
		for (int i = 0; i < MAX_BUFFERS; i++) begin
			any_cand   = any_cand | stat[i].cand_vld;
			any_clash  = any_clash | stat[i].clash;
			bus_off    = bus_off | stat[i].off_sel;
			bus_end    = bus_end | stat[i].end_sel;
			bus_first  = bus_first | stat[i].first_sel;
			bus_last   = bus_last | stat[i].last_sel;
			tok_vec[i] = stat[i].tok;
			cur_vec[i] = stat[i].cur;
		end
	end

	assign take = (state_q == S_EMIT) && out_free;

	always_comb begin
		ctrl.load      = in_xfer && (cnt_q < CNT_W'(MAX_BUFFERS));
		ctrl.ld_size   = items.size_bytes;
		ctrl.ld_first  = items.first_use;
		ctrl.ld_last   = items.last_use;
		ctrl.count     = cnt_q;
		ctrl.cur_idx   = cur_idx_q;
		ctrl.cur_first = cur_first_q;
		ctrl.cur_last  = cur_last_q;
		ctrl.tok_step  = ((state_q == S_SCAN) && sc_q[0]) || (state_q == S_POOL) || take;
		ctrl.tok_clr   = ((state_q == S_SCAN) && last_sc) ||
			((state_q == S_LAST) && results.ready);
		ctrl.wr_cur    = state_q == S_WRITE;
		ctrl.wr_off    = best_off_q;
		ctrl.wr_end    = end_new_q;
		ctrl.clr_marks = (state_q == S_LAST) && results.ready;
		ctrl.probe_lo  = al_s3;
		ctrl.probe_hi  = hi_s3;
		tok_inject     = ((state_q == S_SCAN) && sc_q == SC_W'(1)) || (state_q == S_POOL);
	end

	// candidate pipeline: fetch, align, range end; clash check against the chain after s3
	always_ff @(posedge clk) begin
		if (sc_q == SC_W'(0))
			cand_s1 <= '0;
		else if (sc_q == SC_W'(1))
			cand_s1 <= hw_q;
		else
			cand_s1 <= sc_q[0] ? bus_end : bus_off;
		cand_s2 <= cand_s1;
		al_s2   <= round_up(cand_s1, lg);
		cand_s3 <= cand_s2;
		al_s3   <= al_s2;
		gap_s3  <= al_s2 - cand_s2;
		hi_s3   <= {1'b0, al_s2} + (OFF_W+1)'(cur_size_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN) && (sc_q < SC_W'(2) || any_cand);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PICK) begin
			cur_idx_q  <= stat[MAX_BUFFERS-1].pick.idx;
			cur_size_q <= stat[MAX_BUFFERS-1].pick.size;
		end
		if (state_q == S_CUR) begin
			cur_first_q <= bus_first;
			cur_last_q  <= bus_last;
		end
		if (vld_s3 && !any_clash && (!found_q || gap_s3 < best_gap_q ||
				(gap_s3 == best_gap_q && cand_s3 < best_cand_q))) begin
			best_gap_q  <= gap_s3;
			best_cand_q <= cand_s3;
			best_off_q  <= al_s3;
		end
		if (state_q == S_COMMIT)
			end_new_q <= {1'b0, best_off_q} + (OFF_W+1)'(cur_size_q);
		if (state_q == S_POOL)
			pool_q <= round_up(hw_q, lg);
		if (take) begin
			r_idx_q  <= oi_q[IDX_W-1:0];
			r_off_q  <= bus_off;
			r_pool_q <= pool_q;
			r_drop_q <= ovf_q;
			r_last_q <= oi_q == cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			placed_n_q <= '0;
			wait_q     <= '0;
			oi_q       <= '0;
			sc_q       <= '0;
			drain_q    <= '0;
			ovf_q      <= 1'b0;
			hw_q       <= '0;
			found_q    <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			if (vld_s3 && !any_clash)
				found_q <= 1'b1;
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (ctrl.load)
							cnt_q <= cnt_q + CNT_W'(1);
						else
							ovf_q <= 1'b1;
						if (items.final_buffer) begin
							hw_q       <= '0;
							placed_n_q <= '0;
							wait_q     <= '0;
							state_q    <= S_PICK;
						end
					end
				end
				S_PICK: begin
					wait_q <= wait_q + CNT_W'(1);
					if (wait_q == CNT_W'(MAX_BUFFERS))
						state_q <= S_CUR;
				end
				S_CUR: begin
					found_q <= 1'b0;
					sc_q    <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					sc_q <= sc_q + SC_W'(1);
					if (last_sc) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2)
						state_q <= S_COMMIT;
				end
				S_COMMIT: state_q <= S_WRITE;
				S_WRITE: begin
					if (end_new_q > {1'b0, hw_q})
						hw_q <= end_new_q[OFF_W-1:0];
					placed_n_q <= placed_n_q + CNT_W'(1);
					wait_q     <= '0;
					if (placed_n_q + CNT_W'(1) == cnt_q)
						state_q <= S_POOL;
					else
						state_q <= S_PICK;
				end
				S_POOL: begin
					oi_q    <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						oi_q <= oi_q + CNT_W'(1);
						if (oi_q == cnt_q - CNT_W'(1))
							state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (results.ready) begin
						ov_q    <= 1'b0;
						cnt_q   <= '0;
						hw_q    <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign items.ready          = state_q == S_LOAD;
	assign results.valid        = ov_q;
	assign results.buffer_index = r_idx_q;
	assign results.slot_offset  = r_off_q;
	assign results.pool_bytes   = r_pool_q;
	assign results.dropped_any  = r_drop_q;
	assign results.last_result  = r_last_q;

	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (state_q == S_EMIT || state_q == S_LAST))
		else $error("result pending outside emit");
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one token in chain");
	a_cur_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> $onehot(cur_vec))
		else $error("commit does not select exactly one cell");
	a_placed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (placed_n_q < cnt_q))
		else $error("placing beyond loaded count");

endmodule
`default_nettype wire
